// ===== src/sphere_pair_contact_geometry_macros.svh =====
// Assertion helpers for the sphere pair contact geometry checker.
// They expect clk and rst_n in the scope where they are used.
`ifndef SPHERE_PAIR_CONTACT_GEOMETRY_MACROS_SVH
`define SPHERE_PAIR_CONTACT_GEOMETRY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPCG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spcg check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SPCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spcg check failed one cycle later");

`endif

// ===== src/spcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spcg_pkg;

  // Coordinate and normal formats.
  localparam int CW = 32;
  localparam int NF = 14;
  // Difference width, root width and radicand width.
  localparam int DW = CW + 1;
  localparam int RW = DW + 1;
  localparam int SW = 2 * RW;
  // Division numerator width and quotient width.
  localparam int NW = DW + NF;
  localparam int QW = NF + 1;
  // Normal component width.
  localparam int NORMW = QW + 1;
  // Back end widths: depth, product, rounded offset, saturating sum.
  localparam int BW = RW + 2;
  localparam int PW = (BW - 1) + QW;
  localparam int OW = PW - NF;
  localparam int SATW = OW + 1;

  // Record kinds.
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_CONTACT = 2'd1;
  localparam logic [1:0] KIND_LINK    = 2'd2;
  localparam logic [1:0] KIND_OTHER   = 2'd3;

  // Per-pair data that travels alongside the arithmetic.
  typedef struct packed {
    logic [2:0][CW-1:0] first;
    logic [2:0][DW-1:0] dmag;
    logic [2:0]         dneg;
    logic [CW-2:0]      r1;
    logic [CW-2:0]      r2;
    logic [1:0]         kind;
  } item_t;

  // Square root iteration state.
  typedef struct packed {
    logic [SW-1:0] s;
    logic [RW:0]   rem;
    logic [RW-1:0] root;
  } sq_t;

  // Division iteration state for three components.
  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] num;
    logic [2:0][QW-1:0] q;
    logic [RW-1:0]      dlen;
  } dv_t;

  // Saturate a signed value to the coordinate range.
  function automatic logic [CW-1:0] sat_cw(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    hi = SATW'(signed'({1'b0, {(CW-1){1'b1}}}));
    lo = -hi - SATW'(1);
    if (v > hi) begin
      sat_cw = hi[CW-1:0];
    end else if (v < lo) begin
      sat_cw = lo[CW-1:0];
    end else begin
      sat_cw = v[CW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/spcg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spcg_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [1:0]                     en,
  input  wire logic                           in_vld,
  input  wire logic [2:0][spcg_pkg::CW-1:0]   first,
  input  wire logic [2:0][spcg_pkg::CW-1:0]   second,
  input  wire logic [spcg_pkg::CW-2:0]        r1,
  input  wire logic [spcg_pkg::CW-2:0]        r2,
  input  wire logic [1:0]                     kind,
  output logic [1:0]                          vld,
  output spcg_pkg::item_t                     item,
  output spcg_pkg::sq_t                       sq
);
  import spcg_pkg::*;

  logic [1:0]                vld_r;
  item_t                     it0_r, it0_nxt;
  logic [2:0][2*DW-1:0]      sq0_r, sq0_nxt;
  item_t                     it1_r;
  logic [SW-1:0]             s1_r, s1_nxt;

  // Differences, magnitudes and their squares.
  always_comb begin
    logic signed [DW-1:0] diff;
    it0_nxt = '0;
    sq0_nxt = '0;
    it0_nxt.first = first;
    it0_nxt.r1 = r1;
    it0_nxt.r2 = r2;
    it0_nxt.kind = kind;
    for (int c = 0; c < 3; c++) begin
      diff = signed'({second[c][CW-1], second[c]}) - signed'({first[c][CW-1], first[c]});
      it0_nxt.dneg[c] = diff[DW-1];
      it0_nxt.dmag[c] = diff[DW-1] ? DW'(-diff) : DW'(diff);
      sq0_nxt[c] = it0_nxt.dmag[c] * it0_nxt.dmag[c];
    end
  end

  // Sum of squares.
  assign s1_nxt = SW'(sq0_r[0]) + SW'(sq0_r[1]) + SW'(sq0_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_vld;
      if (en[1]) vld_r[1] <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      it0_r <= it0_nxt;
      sq0_r <= sq0_nxt;
    end
    if (en[1]) begin
      it1_r <= it0_r;
      s1_r  <= s1_nxt;
    end
  end

  assign vld     = vld_r;
  assign item    = it1_r;
  assign sq.s    = s1_r;
  assign sq.rem  = '0;
  assign sq.root = '0;
endmodule
`default_nettype wire

// ===== src/spcg_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spcg_sqrt_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            vld_in,
  input  wire spcg_pkg::item_t item_in,
  input  wire spcg_pkg::sq_t   sq_in,
  output logic                 vld,
  output spcg_pkg::item_t      item,
  output spcg_pkg::sq_t        sq
);
  import spcg_pkg::*;

  logic  vld_r;
  item_t item_r;
  sq_t   sq_r, sq_nxt;

  // One root bit: bring down two radicand bits and try the next odd term.
  always_comb begin
    logic [RW+2:0] rem2;
    logic [RW+2:0] trial;
    rem2  = {sq_in.rem, sq_in.s[SW-1:SW-2]};
    trial = {1'b0, sq_in.root, 2'b01};
    sq_nxt.s = {sq_in.s[SW-3:0], 2'b00};
    if (rem2 >= trial) begin
      sq_nxt.rem  = (RW+1)'(rem2 - trial);
      sq_nxt.root = {sq_in.root[RW-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = (RW+1)'(rem2);
      sq_nxt.root = {sq_in.root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_in;
      sq_r   <= sq_nxt;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;
  assign sq   = sq_r;
endmodule
`default_nettype wire

// ===== src/spcg_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spcg_div_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            vld_in,
  input  wire spcg_pkg::item_t item_in,
  input  wire spcg_pkg::dv_t   dv_in,
  output logic                 vld,
  output spcg_pkg::item_t      item,
  output spcg_pkg::dv_t        dv
);
  import spcg_pkg::*;

  logic  vld_r;
  item_t item_r;
  dv_t   dv_r, dv_nxt;

  // One quotient bit for each of the three components.
  always_comb begin
    logic [RW:0] r2;
    dv_nxt.dlen = dv_in.dlen;
    for (int c = 0; c < 3; c++) begin
      r2 = {dv_in.rem[c], dv_in.num[c][QW-1]};
      dv_nxt.num[c] = {dv_in.num[c][QW-2:0], 1'b0};
      if (r2 >= {1'b0, dv_in.dlen}) begin
        dv_nxt.rem[c] = RW'(r2 - {1'b0, dv_in.dlen});
        dv_nxt.q[c]   = {dv_in.q[c][QW-2:0], 1'b1};
      end else begin
        dv_nxt.rem[c] = RW'(r2);
        dv_nxt.q[c]   = {dv_in.q[c][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_in;
      dv_r   <= dv_nxt;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;
  assign dv   = dv_r;
endmodule
`default_nettype wire

// ===== src/spcg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spcg_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [2:0]                       en,
  input  wire logic                             vld_in,
  input  wire spcg_pkg::item_t                  item_in,
  input  wire spcg_pkg::dv_t                    dv_in,
  output logic [2:0]                            vld,
  output logic                                  hit,
  output logic [2:0][spcg_pkg::NORMW-1:0]       normal,
  output logic [spcg_pkg::CW-1:0]               depth,
  output logic [2:0][spcg_pkg::CW-1:0]          point,
  output logic                                  create_record
);
  import spcg_pkg::*;

  logic [2:0] vld_r;

  // Stage 0: depth, lever arm and signed normal.
  logic [2:0][CW-1:0]    first0_r;
  logic [1:0]            kind0_r;
  logic                  dpos0_r, dpos0_nxt;
  logic [CW-1:0]         dsat0_r, dsat0_nxt;
  logic                  tneg0_r, tneg0_nxt;
  logic [BW-2:0]         tmag0_r, tmag0_nxt;
  logic [2:0][QW-1:0]    q0_r, q0_nxt;
  logic [2:0]            nneg0_r;
  logic [2:0][NORMW-1:0] n0_r, n0_nxt;

  // Stage 1: products.
  logic [2:0][CW-1:0]    first1_r;
  logic [1:0]            kind1_r;
  logic                  dpos1_r;
  logic [CW-1:0]         dsat1_r;
  logic [2:0][NORMW-1:0] n1_r;
  logic [2:0][PW-1:0]    prod1_r, prod1_nxt;
  logic [2:0]            sneg1_r, sneg1_nxt;

  // Stage 2: output register.
  logic                  hit_r, hit_nxt;
  logic [2:0][NORMW-1:0] n2_r, n2_nxt;
  logic [CW-1:0]         depth_r, depth_nxt;
  logic [2:0][CW-1:0]    point_r, point_nxt;
  logic                  create_r, create_nxt;

  always_comb begin
    logic signed [BW-1:0] dist_s;
    logic signed [BW-1:0] r1_s;
    logic signed [BW-1:0] r2_s;
    logic signed [BW-1:0] dep;
    logic signed [BW-1:0] t;
    dist_s = signed'(BW'(dv_in.dlen));
    r1_s   = signed'(BW'(item_in.r1));
    r2_s   = signed'(BW'(item_in.r2));
    dep    = r1_s + r2_s - dist_s;
    t      = r1_s - r2_s + dist_s;
    dpos0_nxt = !dep[BW-1] && (dep != '0);
    dsat0_nxt = sat_cw(SATW'(dep));
    tneg0_nxt = t[BW-1];
    tmag0_nxt = t[BW-1] ? (BW-1)'(-t) : (BW-1)'(t);
    for (int c = 0; c < 3; c++) begin
      // A zero distance gives a zero normal.
      q0_nxt[c] = (dv_in.dlen == '0) ? '0 : dv_in.q[c];
      n0_nxt[c] = item_in.dneg[c] ? NORMW'(-{1'b0, q0_nxt[c]}) : NORMW'({1'b0, q0_nxt[c]});
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod1_nxt[c] = PW'(tmag0_r) * PW'(q0_r[c]);
      sneg1_nxt[c] = tneg0_r ^ nneg0_r[c];
    end
  end

  // Contact point, rounded half away from zero, and the record decision.
  always_comb begin
    logic [PW:0]            rnd;
    logic [OW-1:0]          off;
    logic signed [SATW-1:0] sum;
    logic                   full;
    for (int c = 0; c < 3; c++) begin
      rnd = {1'b0, prod1_r[c]} + (PW+1)'(1 << NF);
      off = OW'(rnd >> (NF + 1));
      if (sneg1_r[c]) begin
        sum = SATW'(signed'(first1_r[c])) - signed'({1'b0, off});
      end else begin
        sum = SATW'(signed'(first1_r[c])) + signed'({1'b0, off});
      end
      point_nxt[c] = sat_cw(sum);
    end
    full = ((kind1_r == KIND_NONE) || (kind1_r == KIND_CONTACT)) && dpos1_r;
    hit_nxt    = full || (kind1_r == KIND_LINK);
    create_nxt = full && (kind1_r == KIND_NONE);
    n2_nxt     = hit_nxt ? n1_r : '0;
    depth_nxt  = full ? dsat1_r : '0;
    if (!full) point_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= vld_in;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      first0_r <= item_in.first;
      kind0_r  <= item_in.kind;
      dpos0_r  <= dpos0_nxt;
      dsat0_r  <= dsat0_nxt;
      tneg0_r  <= tneg0_nxt;
      tmag0_r  <= tmag0_nxt;
      q0_r     <= q0_nxt;
      nneg0_r  <= item_in.dneg;
      n0_r     <= n0_nxt;
    end
    if (en[1]) begin
      first1_r <= first0_r;
      kind1_r  <= kind0_r;
      dpos1_r  <= dpos0_r;
      dsat1_r  <= dsat0_r;
      n1_r     <= n0_r;
      prod1_r  <= prod1_nxt;
      sneg1_r  <= sneg1_nxt;
    end
    if (en[2]) begin
      hit_r    <= hit_nxt;
      n2_r     <= n2_nxt;
      depth_r  <= depth_nxt;
      point_r  <= point_nxt;
      create_r <= create_nxt;
    end
  end

  assign vld           = vld_r;
  assign hit           = hit_r;
  assign normal        = n2_r;
  assign depth         = depth_r;
  assign point         = point_r;
  assign create_record = create_r;
endmodule
`default_nettype wire

// ===== src/sphere_pair_contact_geometry.sv =====
// Pipeline: 2 front stages, 34 square root cells, 15 divider cells and 3 back
// stages lie between an accepted word and its result word.
// Throughput: one word per cycle without output stall; each cell stage holds its
// word only while the next one is full and stalled, so bubbles close up on stall.
// Reset: synchronous, active low; clears every stage valid, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module sphere_pair_contact_geometry (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [spcg_pkg::CW-1:0]     in_first_x,
  input  wire logic [spcg_pkg::CW-1:0]     in_first_y,
  input  wire logic [spcg_pkg::CW-1:0]     in_first_z,
  input  wire logic [spcg_pkg::CW-1:0]     in_second_x,
  input  wire logic [spcg_pkg::CW-1:0]     in_second_y,
  input  wire logic [spcg_pkg::CW-1:0]     in_second_z,
  input  wire logic [spcg_pkg::CW-2:0]     in_radius_first,
  input  wire logic [spcg_pkg::CW-2:0]     in_radius_second,
  input  wire logic [1:0]                  in_existing_geometry,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic [spcg_pkg::NORMW-1:0]       out_normal_x,
  output logic [spcg_pkg::NORMW-1:0]       out_normal_y,
  output logic [spcg_pkg::NORMW-1:0]       out_normal_z,
  output logic [spcg_pkg::CW-1:0]          out_depth,
  output logic [spcg_pkg::CW-1:0]          out_point_x,
  output logic [spcg_pkg::CW-1:0]          out_point_y,
  output logic [spcg_pkg::CW-1:0]          out_point_z,
  output logic                             out_create_record
);
  import spcg_pkg::*;

  localparam int SQ0 = 2;
  localparam int DV0 = SQ0 + RW;
  localparam int BK0 = DV0 + QW;
  localparam int NS  = BK0 + 3;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // Stage enables: a stage loads when it is empty or the next one loads.
  always_comb begin
    en[NS-1] = !v[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NS-1];

  logic [2:0][CW-1:0] first_a, second_a;
  assign first_a  = {in_first_z, in_first_y, in_first_x};
  assign second_a = {in_second_z, in_second_y, in_second_x};

  item_t sq_item [RW+1];
  sq_t   sq_st   [RW+1];

  spcg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[1:0]),
    .in_vld (in_valid),
    .first  (first_a),
    .second (second_a),
    .r1     (in_radius_first),
    .r2     (in_radius_second),
    .kind   (in_existing_geometry),
    .vld    (v[1:0]),
    .item   (sq_item[0]),
    .sq     (sq_st[0])
  );

  // Square root chain, one root bit per cell.
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    spcg_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[SQ0+k]),
      .vld_in  (v[SQ0+k-1]),
      .item_in (sq_item[k]),
      .sq_in   (sq_st[k]),
      .vld     (v[SQ0+k]),
      .item    (sq_item[k+1]),
      .sq      (sq_st[k+1])
    );
  end

  item_t dv_item [QW+1];
  dv_t   dv_st   [QW+1];
  dv_t   dv_first;

  // Divider setup: numerator is the magnitude scaled up plus half the distance.
  always_comb begin
    logic [NW-1:0] num;
    dv_first.dlen = sq_st[RW].root;
    for (int c = 0; c < 3; c++) begin
      num = {sq_item[RW].dmag[c], {NF{1'b0}}} + NW'(sq_st[RW].root >> 1);
      dv_first.rem[c] = RW'(num >> QW);
      dv_first.num[c] = num[QW-1:0];
      dv_first.q[c]   = '0;
    end
  end
  assign dv_st[0]   = dv_first;
  assign dv_item[0] = sq_item[RW];

  // Divider chain, one quotient bit per cell.
  for (genvar k = 0; k < QW; k++) begin : g_div
    spcg_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en[DV0+k]),
      .vld_in  (v[DV0+k-1]),
      .item_in (dv_item[k]),
      .dv_in   (dv_st[k]),
      .vld     (v[DV0+k]),
      .item    (dv_item[k+1]),
      .dv      (dv_st[k+1])
    );
  end

  logic [2:0][NORMW-1:0] normal_a;
  logic [2:0][CW-1:0]    point_a;

  spcg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en[NS-1:BK0]),
    .vld_in        (v[BK0-1]),
    .item_in       (dv_item[QW]),
    .dv_in         (dv_st[QW]),
    .vld           (v[NS-1:BK0]),
    .hit           (out_hit),
    .normal        (normal_a),
    .depth         (out_depth),
    .point         (point_a),
    .create_record (out_create_record)
  );

  assign out_normal_x = normal_a[0];
  assign out_normal_y = normal_a[1];
  assign out_normal_z = normal_a[2];
  assign out_point_x  = point_a[0];
  assign out_point_y  = point_a[1];
  assign out_point_z  = point_a[2];
endmodule
`default_nettype wire

// ===== src/spcg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_pair_contact_geometry_macros.svh"
module spcg_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [spcg_pkg::CW-1:0]     in_first_x,
  input wire logic [spcg_pkg::CW-1:0]     in_first_y,
  input wire logic [spcg_pkg::CW-1:0]     in_first_z,
  input wire logic [spcg_pkg::CW-1:0]     in_second_x,
  input wire logic [spcg_pkg::CW-1:0]     in_second_y,
  input wire logic [spcg_pkg::CW-1:0]     in_second_z,
  input wire logic [spcg_pkg::CW-2:0]     in_radius_first,
  input wire logic [spcg_pkg::CW-2:0]     in_radius_second,
  input wire logic [1:0]                  in_existing_geometry,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        out_hit,
  input wire logic [spcg_pkg::NORMW-1:0]  out_normal_x,
  input wire logic [spcg_pkg::NORMW-1:0]  out_normal_y,
  input wire logic [spcg_pkg::NORMW-1:0]  out_normal_z,
  input wire logic [spcg_pkg::CW-1:0]     out_depth,
  input wire logic [spcg_pkg::CW-1:0]     out_point_x,
  input wire logic [spcg_pkg::CW-1:0]     out_point_y,
  input wire logic [spcg_pkg::CW-1:0]     out_point_z,
  input wire logic                        out_create_record
);
  import spcg_pkg::*;

  // A word without a hit carries no geometry at all.
  `SPCG_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0 && out_depth == '0 && out_point_x == '0 && out_point_y == '0 && out_point_z == '0 && !out_create_record)
  // A new record comes only with a hit of positive depth.
  `SPCG_ASSERT_NOW(a_create_depth, out_valid && out_create_record, out_hit && !out_depth[CW-1] && out_depth != '0)
  // A negative depth never reaches the port.
  `SPCG_ASSERT_NOW(a_depth_sign, out_valid, !out_depth[CW-1])
  // A stalled result word stays presented.
  `SPCG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
endmodule

bind sphere_pair_contact_geometry spcg_checker u_spcg_checker (.*);
`default_nettype wire

// ===== tb/sphere_pair_contact_geometry_tb.sv =====
`timescale 1ns / 1ps
module sphere_pair_contact_geometry_tb;
  import spcg_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;

  // One sphere pair as offered on the input channel.
  typedef struct {
    logic signed [CW-1:0] first [3];
    logic signed [CW-1:0] second [3];
    logic [CW-2:0]        r1;
    logic [CW-2:0]        r2;
    logic [1:0]           kind;
  } pair_t;

  // One contact geometry word as expected on the output channel.
  typedef struct {
    logic                 hit;
    logic [NORMW-1:0]     normal [3];
    logic [CW-1:0]        depth;
    logic [CW-1:0]        point [3];
    logic                 create;
  } geom_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CW-1:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic [CW-1:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic [CW-2:0] in_radius_first = '0, in_radius_second = '0;
  logic [1:0] in_existing_geometry = KIND_NONE;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_hit, out_create_record;
  logic [NORMW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [CW-1:0] out_depth, out_point_x, out_point_y, out_point_z;

  geom_t expected_geoms[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_flag = 1'b0;

  sphere_pair_contact_geometry DUT (.*);

  always #HALF_PERIOD clk = ~clk;

  // Saturate a wide signed value to the coordinate range.
  function automatic logic [CW-1:0] clamp_coord(input longint v);
    longint hi;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < -hi - 1) return CW'(-hi - 1);
    return v[CW-1:0];
  endfunction

  // Quantized normal component, rounded half away from zero.
  function automatic logic [NORMW-1:0] unit_component(input longint d, input longint dlen);
    longint q, v;
    if (dlen == 0) return '0;
    q = (((d < 0 ? -d : d) <<< NF) + (dlen >>> 1)) / dlen;
    v = d < 0 ? -q : q;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[NORMW-1:0];
  endfunction

  // first + t * n / 2^(NF+1), product rounded half away from zero.
  function automatic logic [CW-1:0] contact_coord(input longint first, input longint t,
                                                  input longint n);
    longint m;
    m = ((t < 0 ? -t : t) * (n < 0 ? -n : n) + (longint'(1) <<< NF)) >>> (NF + 1);
    return clamp_coord(first + (((t < 0) != (n < 0)) ? -m : m));
  endfunction

  // Contact geometry expected for one pair.
  function automatic geom_t contact_geometry(input pair_t p);
    geom_t g;
    longint f [3];
    longint d [3];
    longint n [3];
    logic [69:0] sum;
    logic [69:0] sq;
    logic [34:0] root, trial;
    longint dlen, depth, t;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      f[i] = longint'(p.first[i]);
      d[i] = longint'(p.second[i]) - f[i];
      sq = 70'(d[i] < 0 ? -d[i] : d[i]);
      sum += sq * sq;
    end
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      trial = root | (35'(1) << b);
      if (70'(trial) * 70'(trial) <= sum) root = trial;
    end
    dlen = longint'(root);
    for (int i = 0; i < 3; i++) n[i] = longint'($signed(unit_component(d[i], dlen)));
    depth = longint'(p.r1) + longint'(p.r2) - dlen;
    g.hit = 1'b0;
    g.create = 1'b0;
    g.depth = '0;
    for (int i = 0; i < 3; i++) begin
      g.normal[i] = '0;
      g.point[i] = '0;
    end
    if (p.kind == KIND_LINK) begin
      g.hit = 1'b1;
      for (int i = 0; i < 3; i++) g.normal[i] = n[i][NORMW-1:0];
    end else if ((p.kind == KIND_NONE || p.kind == KIND_CONTACT) && depth > 0) begin
      t = 2 * longint'(p.r1) - depth;
      g.hit = 1'b1;
      g.create = (p.kind == KIND_NONE);
      g.depth = clamp_coord(depth);
      for (int i = 0; i < 3; i++) begin
        g.normal[i] = n[i][NORMW-1:0];
        g.point[i] = contact_coord(f[i], t, n[i]);
      end
    end
    return g;
  endfunction

  // Offer one pair, with a random gap unless calm, and hold it until accepted.
  task automatic send_pair(input pair_t p);
    bit taken;
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_x <= p.first[0];
    in_first_y <= p.first[1];
    in_first_z <= p.first[2];
    in_second_x <= p.second[0];
    in_second_y <= p.second[1];
    in_second_z <= p.second[2];
    in_radius_first <= p.r1;
    in_radius_second <= p.r2;
    in_existing_geometry <= p.kind;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    expected_geoms.push_back(contact_geometry(p));
  endtask

  function automatic pair_t build_pair(input longint fx, fy, fz, sx, sy, sz,
                                       input longint r1, r2, input logic [1:0] kind);
    pair_t p;
    p.first[0] = fx[CW-1:0];
    p.first[1] = fy[CW-1:0];
    p.first[2] = fz[CW-1:0];
    p.second[0] = sx[CW-1:0];
    p.second[1] = sy[CW-1:0];
    p.second[2] = sz[CW-1:0];
    p.r1 = r1[CW-2:0];
    p.r2 = r2[CW-2:0];
    p.kind = kind;
    return p;
  endfunction

  // Random pair: mostly close pairs at a random scale, some fully random words.
  function automatic pair_t random_pair();
    pair_t p;
    int scale;
    int roll;
    roll = $urandom_range(0, 99);
    p.kind = roll < 40 ? KIND_NONE : roll < 80 ? KIND_CONTACT :
             roll < 90 ? KIND_LINK : KIND_OTHER;
    scale = $urandom_range(0, 28);
    for (int i = 0; i < 3; i++) begin
      p.first[i] = $urandom;
      if ($urandom_range(0, 99) < 15) begin
        p.second[i] = $urandom;
      end else begin
        p.second[i] = p.first[i] + ($signed($urandom) >>> (31 - scale));
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      p.r1 = (CW-1)'($urandom);
      p.r2 = (CW-1)'($urandom);
    end else begin
      p.r1 = (CW-1)'($urandom & ((32'd1 << (scale + 1)) - 1));
      p.r2 = (CW-1)'($urandom & ((32'd1 << (scale + 1)) - 1));
    end
    return p;
  endfunction

  // Receiver: random stall, calm stretches and a long hold-off on request.
  always @(posedge clk) begin
    static int hold_left = 0;
    static bit hold_seen = 1'b0;
    if (hold_flag != hold_seen) begin
      hold_seen = hold_flag;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 34);
    end
  end

  // Check each result word against the oldest expectation; watch for a hang.
  always @(negedge clk) begin
    static int idle_cycles = 0;
    geom_t want;
    logic [NORMW-1:0] got_n [3];
    logic [CW-1:0] got_p [3];
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_geoms.size() == 0) begin
          $display("%0t: unexpected result word", $time);
          errors++;
        end else begin
          want = expected_geoms.pop_front();
          got_n = '{out_normal_x, out_normal_y, out_normal_z};
          got_p = '{out_point_x, out_point_y, out_point_z};
          if (out_hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_hit);
            errors++;
          end
          if (out_create_record !== want.create) begin
            $display("%0t: create_record expected %0b actual %0b", $time, want.create,
                     out_create_record);
            errors++;
          end
          if (out_depth !== want.depth) begin
            $display("%0t: depth expected %h actual %h", $time, want.depth, out_depth);
            errors++;
          end
          for (int i = 0; i < 3; i++) begin
            if (got_n[i] !== want.normal[i]) begin
              $display("%0t: normal[%0d] expected %h actual %h", $time, i,
                       want.normal[i], got_n[i]);
              errors++;
            end
            if (got_p[i] !== want.point[i]) begin
              $display("%0t: point[%0d] expected %h actual %h", $time, i,
                       want.point[i], got_p[i]);
              errors++;
            end
          end
        end
      end
    end
  end

  // Extremes, every record kind, coincident centres and saturation.
  task automatic test_directed();
    longint mx, mn, rmax;
    mx = 64'sh7FFF_FFFF;
    mn = -64'sh8000_0000;
    rmax = 64'sh7FFF_FFFF;
    send_pair(build_pair(0, 0, 0, 3 <<< 16, 4 <<< 16, 0, 3 <<< 16, 3 <<< 16, KIND_NONE));
    send_pair(build_pair(0, 0, 0, 3 <<< 16, 4 <<< 16, 0, 3 <<< 16, 3 <<< 16, KIND_CONTACT));
    send_pair(build_pair(0, 0, 0, 3 <<< 16, 4 <<< 16, 0, 1 <<< 16, 1 <<< 16, KIND_NONE));
    send_pair(build_pair(0, 0, 0, -5 <<< 16, 0, 0, 0, 0, KIND_LINK));
    send_pair(build_pair(0, 0, 0, 1, 1, 1, rmax, rmax, KIND_OTHER));
    send_pair(build_pair(100, -7, 9, 100, -7, 9, 5, 6, KIND_NONE));
    send_pair(build_pair(100, -7, 9, 100, -7, 9, 0, 0, KIND_CONTACT));
    send_pair(build_pair(mx, mx, mx, mx, mx, mx, rmax, rmax, KIND_NONE));
    send_pair(build_pair(mn, mn, mn, mx, mx, mx, rmax, rmax, KIND_CONTACT));
    send_pair(build_pair(mx, mx, mx, mn, mn, mn, rmax, rmax, KIND_NONE));
    send_pair(build_pair(mx, mn, mx, mn, mx, mn, 0, 0, KIND_LINK));
    send_pair(build_pair(mx - 2, 0, mn + 2, mx - 1, 0, mn + 1, rmax, 0, KIND_NONE));
    send_pair(build_pair(mn, 0, 0, mn + 1, 0, 0, 0, rmax, KIND_CONTACT));
    send_pair(build_pair(0, 0, 0, -1, -1, -1, 1, 1, KIND_NONE));
    send_pair(build_pair(0, 0, 0, 0, 0, 1, 1, 0, KIND_NONE));
    send_pair(build_pair(0, 0, 0, 0, 0, 0, 0, 0, KIND_OTHER));
  endtask

  // Random pairs, with a stretch where neither side idles.
  task automatic test_random(input int count);
    for (int k = 0; k < count; k++) begin
      calm = (k >= count / 3) && (k < count / 2);
      send_pair(random_pair());
    end
    calm = 1'b0;
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall its input.
  task automatic test_backpressure();
    hold_flag = ~hold_flag;
    calm = 1'b1;
    for (int k = 0; k < 150; k++) send_pair(random_pair());
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1300);
    test_backpressure();
    test_random(150);
    in_valid <= 1'b0;
    while (expected_geoms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
